// ----- rtl/rsct_pkg.sv -----
// Package for the resizing stack capacity tracker.
// Holds sizes, configuration register indexes and the request/result types.
// No dependencies.
`default_nettype none

package rsct_pkg;

	// Physical stack memory
	localparam int PHYS_DEPTH = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(PHYS_DEPTH);
	localparam int CNT_W      = 11;           // occupancy and capacity fields
	localparam int TOT_W      = 32;           // saturating totals
	localparam int CFG_W      = 11;           // widest configuration register
	localparam int CFG_IDX_W  = 3;

	// Shared multiplier: capacity times a 9-bit operand
	localparam int MUL_B_W = 9;
	localparam int PROD_W  = CNT_W + MUL_B_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CAP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 3'd5;

	// Command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef struct packed {
		logic                         cmd;
		logic signed [DATA_WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] pop_value;
		logic                         pop_valid;
		logic                         overflow;
		logic                         resized;
		logic [CNT_W-1:0]             item_count;
		logic [CNT_W-1:0]             capacity;
		logic [CNT_W-1:0]             peak_capacity;
		logic [TOT_W-1:0]             resize_total;
		logic [TOT_W-1:0]             command_total;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/resizing_stack_capacity_tracker_core.sv -----
// Top level of the resizing stack capacity tracker: sequencer, shared multiplier,
// stack memory and result register. Depends on rsct_pkg.
`default_nettype none

// LIFO stack over a 1024 x 32 memory with a logical capacity that grows or
// shrinks with the fill level before every push or pop request. A request runs
// through three passes of the one shared 11x9 multiplier (full check, empty
// check, scaling), a step that clamps and applies the new capacity, the memory
// access (pop read data is registered) and the load of the result register.
// The sequencer returns to idle before it takes the next request, so a new
// request is not accepted until the result of the last one has been loaded.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not stop the next request from being accepted and worked
// on up to its result step, which then waits for the output register to free up.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user is to
// write it only while idle, which the block itself does not enforce. Writing
// initial_capacity reloads capacity and peak capacity at once.
module resizing_stack_capacity_tracker_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire rsct_pkg::req_t                   in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output rsct_pkg::rsp_t                        out_data,
	input  wire logic                             cfg_we,
	input  wire logic [rsct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rsct_pkg::CFG_W-1:0]       cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_F = 3'd1;
	localparam logic [2:0] ST_MUL_E = 3'd2;
	localparam logic [2:0] ST_MUL_S = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;
	localparam logic [2:0] ST_EXEC  = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	localparam logic [rsct_pkg::CNT_W-1:0] DEPTH_C  = rsct_pkg::CNT_W'(rsct_pkg::PHYS_DEPTH);
	localparam logic [rsct_pkg::TOT_W-1:0] TOT_MAX  = '1;
	localparam int                         SCALE_W  = rsct_pkg::PROD_W - 5;

	// Clamp a scaled capacity to 1 .. depth and to no less than the occupancy
	function automatic logic [rsct_pkg::CNT_W-1:0] clamp_cap(
		input logic [SCALE_W-1:0]          c,
		input logic [rsct_pkg::CNT_W-1:0]  occ
	);
		logic [SCALE_W-1:0] r;
		r = c;
		if (r == '0) r = SCALE_W'(1);
		if (r < SCALE_W'(occ)) r = SCALE_W'(occ);
		if (r > SCALE_W'(DEPTH_C)) r = SCALE_W'(DEPTH_C);
		return r[rsct_pkg::CNT_W-1:0];
	endfunction

	// Configuration registers
	logic [8:0]                   full_th_q;
	logic [8:0]                   empty_th_q;
	logic [7:0]                   growth_q;
	logic [7:0]                   shrink_q;
	logic [rsct_pkg::CNT_W-1:0]   min_cap_q;

	// Control state
	logic [2:0]                   state_q;
	logic [rsct_pkg::CNT_W-1:0]   occ_q;
	logic [rsct_pkg::CNT_W-1:0]   cap_q;
	logic [rsct_pkg::CNT_W-1:0]   peak_q;
	logic [rsct_pkg::TOT_W-1:0]   rsz_cnt_q;
	logic [rsct_pkg::TOT_W-1:0]   cmd_cnt_q;
	logic                         grow_q;
	logic                         shrk_q;
	logic                         pop_ok_q;
	logic                         ovf_q;
	logic                         resized_q;
	logic                         out_valid_q;

	// Payload registers
	rsct_pkg::req_t               req_q;
	logic [rsct_pkg::PROD_W-1:0]  prod_q;
	logic [rsct_pkg::DATA_WIDTH-1:0] rdata_q;
	rsct_pkg::rsp_t               out_q;

	logic [rsct_pkg::DATA_WIDTH-1:0] mem [rsct_pkg::PHYS_DEPTH];

	// Combinational helpers
	logic [rsct_pkg::MUL_B_W-1:0] mul_b;
	logic [rsct_pkg::PROD_W-1:0]  mul_p;
	logic [rsct_pkg::CNT_W-1:0]   occ_m1;
	logic [rsct_pkg::PROD_W-1:0]  lhs;
	logic                         above_full;
	logic                         at_or_below_empty;
	logic [SCALE_W-1:0]           scaled;
	logic [rsct_pkg::CNT_W-1:0]   next_cap;
	logic                         push_ok;
	logic                         pop_ok;
	logic                         mem_we;
	logic                         mem_re;
	logic                         resp_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MUL_F: mul_b = full_th_q;
			ST_MUL_E: mul_b = empty_th_q;
			default:  mul_b = grow_q ? {1'b0, growth_q} : {1'b0, shrink_q};
		endcase
	end

	assign mul_p = rsct_pkg::PROD_W'(cap_q) * rsct_pkg::PROD_W'(mul_b);

	// Top index times 256; an empty stack never grows and always counts as low
	assign occ_m1            = occ_q - rsct_pkg::CNT_W'(1);
	assign lhs               = {2'b00, occ_m1[rsct_pkg::ADDR_W-1:0], 8'h00};
	assign above_full        = (occ_q != '0) && (lhs > prod_q);
	assign at_or_below_empty = (occ_q == '0) || (lhs <= prod_q);

	// Scaled capacity: Q4.4 on grow, Q0.8 on shrink, truncated
	assign scaled   = grow_q ? prod_q[rsct_pkg::PROD_W-2:4]
	                         : SCALE_W'(prod_q[rsct_pkg::PROD_W-2:8]);
	assign next_cap = (grow_q || shrk_q) ? clamp_cap(scaled, occ_q) : cap_q;

	assign push_ok   = (req_q.cmd == rsct_pkg::CMD_PUSH) && (occ_q != DEPTH_C);
	assign pop_ok    = (req_q.cmd == rsct_pkg::CMD_POP) && (occ_q != '0);
	assign mem_we    = (state_q == ST_EXEC) && push_ok;
	assign mem_re    = (state_q == ST_EXEC) && pop_ok;
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	// Stack memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[occ_q[rsct_pkg::ADDR_W-1:0]] <= req_q.value;
		end
		if (mem_re) begin
			rdata_q <= mem[occ_m1[rsct_pkg::ADDR_W-1:0]];
		end
	end

	// Request latch and multiplier result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		prod_q <= mul_p;
	end

	// Sequencer and tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_th_q   <= 9'd218;
			empty_th_q  <= 9'd38;
			growth_q    <= 8'd32;
			shrink_q    <= 8'd128;
			min_cap_q   <= rsct_pkg::CNT_W'(10);
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cap_q       <= rsct_pkg::CNT_W'(10);
			peak_q      <= rsct_pkg::CNT_W'(10);
			rsz_cnt_q   <= '0;
			cmd_cnt_q   <= '0;
			grow_q      <= 1'b0;
			shrk_q      <= 1'b0;
			pop_ok_q    <= 1'b0;
			ovf_q       <= 1'b0;
			resized_q   <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					rsct_pkg::REG_FULL_TH:  full_th_q  <= cfg_data[8:0];
					rsct_pkg::REG_EMPTY_TH: empty_th_q <= cfg_data[8:0];
					rsct_pkg::REG_GROWTH:   growth_q   <= cfg_data[7:0];
					rsct_pkg::REG_SHRINK:   shrink_q   <= cfg_data[7:0];
					rsct_pkg::REG_MIN_CAP:  min_cap_q  <= cfg_data;
					rsct_pkg::REG_INIT_CAP: begin
						cap_q  <= clamp_cap(SCALE_W'(cfg_data), occ_q);
						peak_q <= clamp_cap(SCALE_W'(cfg_data), occ_q);
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL_F;
					end
				end
				// prod_q <= cap * full threshold
				ST_MUL_F: state_q <= ST_MUL_E;
				// decide grow; prod_q <= cap * empty threshold
				ST_MUL_E: begin
					grow_q  <= above_full;
					state_q <= ST_MUL_S;
				end
				// decide shrink; prod_q <= cap * chosen factor
				ST_MUL_S: begin
					shrk_q  <= !grow_q && at_or_below_empty && (cap_q > min_cap_q);
					state_q <= ST_APPLY;
				end
				// clamp and apply the new capacity
				ST_APPLY: begin
					resized_q <= (next_cap != cap_q);
					if (next_cap != cap_q) begin
						cap_q <= next_cap;
						if (next_cap > peak_q) begin
							peak_q <= next_cap;
						end
						if (rsz_cnt_q != TOT_MAX) begin
							rsz_cnt_q <= rsz_cnt_q + rsct_pkg::TOT_W'(1);
						end
					end
					state_q <= ST_EXEC;
				end
				// push or pop
				ST_EXEC: begin
					pop_ok_q <= pop_ok;
					ovf_q    <= (req_q.cmd == rsct_pkg::CMD_PUSH) && !push_ok;
					if (push_ok) begin
						occ_q <= occ_q + rsct_pkg::CNT_W'(1);
					end else if (pop_ok) begin
						occ_q <= occ_m1;
					end
					if ((push_ok || pop_ok) && (cmd_cnt_q != TOT_MAX)) begin
						cmd_cnt_q <= cmd_cnt_q + rsct_pkg::TOT_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_q.pop_value     <= pop_ok_q ? rdata_q : '0;
			out_q.pop_valid     <= pop_ok_q;
			out_q.overflow      <= ovf_q;
			out_q.resized       <= resized_q;
			out_q.item_count    <= occ_q;
			out_q.capacity      <= cap_q;
			out_q.peak_capacity <= peak_q;
			out_q.resize_total  <= rsz_cnt_q;
			out_q.command_total <= cmd_cnt_q;
		end
	end

`ifndef SYNTHESIS
	// Capacity always within 1 .. depth
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (cap_q <= DEPTH_C))
		else $error("capacity out of range");

	// Occupancy never exceeds the physical depth
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("occupancy beyond depth");

	// Peak tracks the largest capacity
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= cap_q)
		else $error("peak below capacity");

	// Resize total moves only out of the apply step
	a_rsz_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(rsz_cnt_q) |-> $past(state_q) == ST_APPLY)
		else $error("resize total changed outside apply");
`endif

endmodule

`default_nettype wire
